// ===== rtl/vap_pkg.sv =====
`timescale 1ns / 1ps
package vap_pkg;

  localparam int COMPONENTS_DEF    = 4;
  localparam int ADDRESS_WIDTH_DEF = 32;

  localparam int COMP_W  = 32;
  localparam int CODE_W  = 32;
  localparam int PROD_W  = 40;
  localparam int FMT_W   = 4;
  localparam int COUNT_W = 3;
  localparam int OFFS_W  = 16;
  localparam int BCNT_W  = 5;

  localparam logic [FMT_W-1:0] FMT_FLOAT32 = 4'd0;
  localparam logic [FMT_W-1:0] FMT_HALF    = 4'd1;
  localparam logic [FMT_W-1:0] FMT_UNORM16 = 4'd2;
  localparam logic [FMT_W-1:0] FMT_UINT16  = 4'd3;
  localparam logic [FMT_W-1:0] FMT_SNORM16 = 4'd4;
  localparam logic [FMT_W-1:0] FMT_INT16   = 4'd5;
  localparam logic [FMT_W-1:0] FMT_UNORM8  = 4'd6;
  localparam logic [FMT_W-1:0] FMT_UINT8   = 4'd7;
  localparam logic [FMT_W-1:0] FMT_SNORM8  = 4'd8;
  localparam logic [FMT_W-1:0] FMT_INT8    = 4'd9;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  // Element size in bytes; zero for codes that name no format.
  function automatic logic [2:0] elem_size(input logic [FMT_W-1:0] fmt);
    logic [2:0] sz;
    if (fmt == FMT_FLOAT32) sz = 3'd4;
    else if (fmt <= FMT_INT16) sz = 3'd2;
    else if (fmt <= FMT_INT8) sz = 3'd1;
    else sz = 3'd0;
    return sz;
  endfunction

  function automatic logic is_norm(input logic [FMT_W-1:0] fmt);
    return fmt == FMT_UNORM16 || fmt == FMT_SNORM16 || fmt == FMT_UNORM8 ||
           fmt == FMT_SNORM8;
  endfunction

  function automatic logic is_signed_fmt(input logic [FMT_W-1:0] fmt);
    return fmt == FMT_SNORM16 || fmt == FMT_INT16 || fmt == FMT_SNORM8 ||
           fmt == FMT_INT8;
  endfunction

  // Upper end of the output range.
  function automatic logic [16:0] range_hi(input logic [FMT_W-1:0] fmt);
    logic [16:0] h;
    if (fmt == FMT_UNORM16 || fmt == FMT_UINT16) h = 17'd65535;
    else if (fmt == FMT_SNORM16 || fmt == FMT_INT16) h = 17'd32767;
    else if (fmt == FMT_UNORM8 || fmt == FMT_UINT8) h = 17'd255;
    else h = 17'd127;
    return h;
  endfunction

  // Multiplier applied to the mantissa: the scale for norm formats, one otherwise.
  function automatic logic [15:0] mul_scale(input logic [FMT_W-1:0] fmt);
    return is_norm(fmt) ? 16'(range_hi(fmt)) : 16'd1;
  endfunction

  // Bit position of the leading one of mul_scale.
  function automatic logic [3:0] scale_msb(input logic [FMT_W-1:0] fmt);
    logic [3:0] m;
    if (!is_norm(fmt)) m = 4'd0;
    else if (fmt == FMT_UNORM16) m = 4'd15;
    else if (fmt == FMT_SNORM16) m = 4'd14;
    else if (fmt == FMT_UNORM8) m = 4'd7;
    else m = 4'd6;
    return m;
  endfunction

  function automatic logic [15:0] half_encode(input logic [31:0] b);
    logic [30:0] em;
    logic [30:0] t;
    logic [14:0] h;
    em = b[30:0];
    t  = em - 31'(112 << 23) + 31'(1 << 12);
    if (em > 31'(255 << 23)) h = 15'h7E00;
    else if (em >= 31'(143 << 23)) h = 15'h7C00;
    else if (em < 31'(113 << 23)) h = 15'h0000;
    else h = t[27:13];
    return {b[31], h};
  endfunction

endpackage

// ===== rtl/vap_lane.sv =====
`timescale 1ns / 1ps
module vap_lane (
  input  logic                            clk,
  input  vap_pkg::stage_en_t              en,
  input  logic [vap_pkg::FMT_W-1:0]       fmt,
  input  logic [vap_pkg::COMP_W-1:0]      comp,
  output logic [vap_pkg::CODE_W-1:0]      code
);

  logic [vap_pkg::COMP_W-1:0] bits_r;
  logic [vap_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [vap_pkg::CODE_W-1:0] code_r, code_nxt;

  // Stage one: mantissa times scale, exact.
  always_comb begin
    prod_nxt = vap_pkg::PROD_W'({(comp[30:23] != 8'd0), comp[22:0]}) *
               vap_pkg::PROD_W'(vap_pkg::mul_scale(fmt));
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      bits_r <= comp;
      prod_r <= prod_nxt;
    end
    if (en.s2) begin
      code_r <= code_nxt;
    end
  end

  // Stage two: integer codes round to float32, then an integer, clamp and sign.
  always_comb begin
    logic        sgn;
    logic [7:0]  ex;
    logic [30:0] em;
    logic        nan;
    logic        big;
    logic [4:0]  g;
    logic [5:0]  pidx;
    logic        half_b;
    logic        sticky;
    logic        lsb;
    logic [24:0] pt;
    logic [8:0]  dd;
    logic [5:0]  d6;
    logic [41:0] rsum;
    logic [41:0] rint;
    logic [16:0] hi;
    logic [16:0] mag;
    logic [31:0] sval;
    sgn  = bits_r[31];
    ex   = bits_r[30:23];
    em   = bits_r[30:0];
    nan  = em > 31'h7F800000;
    hi   = vap_pkg::range_hi(fmt);
    big  = vap_pkg::is_norm(fmt) ? (em > 31'h3F800000) : (ex >= 8'd143);
    pidx = 6'd24 + 6'(vap_pkg::scale_msb(fmt));
    g    = 5'(vap_pkg::scale_msb(fmt)) + 5'(prod_r[pidx]);
    half_b = (g != 5'd0) && prod_r[6'(g) - 6'd1];
    sticky = (g > 5'd1) &&
             ((prod_r & ((40'd1 << (6'(g) - 6'd1)) - 40'd1)) != 40'd0);
    lsb  = prod_r[6'(g)];
    pt   = 25'(prod_r >> g) + 25'(half_b & (sticky | lsb));
    dd   = 9'd150 - {1'b0, ex} - 9'(g);
    d6   = dd[5:0];
    rsum = 42'(pt) + (42'd1 << (d6 - 6'd1));
    rint = rsum >> d6;
    if (rint > 42'(hi)) mag = hi;
    else mag = rint[16:0];
    if (nan || (sgn && !vap_pkg::is_signed_fmt(fmt))) mag = 17'd0;
    else if (big) mag = hi;
    else if (ex < 8'd110) mag = 17'd0;
    sval = sgn ? -32'(mag) : 32'(mag);
    if (fmt == vap_pkg::FMT_FLOAT32) code_nxt = bits_r;
    else if (fmt == vap_pkg::FMT_HALF) code_nxt = 32'(vap_pkg::half_encode(bits_r));
    else code_nxt = sval;
  end

  assign code = code_r;

endmodule

// ===== rtl/vap_merge.sv =====
`timescale 1ns / 1ps
module vap_merge #(
  parameter int COMPONENTS    = vap_pkg::COMPONENTS_DEF,
  parameter int ADDRESS_WIDTH = vap_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [vap_pkg::FMT_W-1:0]         fmt,
  input  logic [vap_pkg::COUNT_W-1:0]       count_cfg,
  input  logic [vap_pkg::OFFS_W-1:0]        offset,
  input  logic [31:0]                       base,
  input  logic [vap_pkg::CODE_W-1:0]        codes [COMPONENTS],
  output logic [31:0]                       write_address,
  output logic [63:0]                       packed_low,
  output logic [63:0]                       packed_high,
  output logic [vap_pkg::BCNT_W-1:0]        byte_count
);

  localparam logic [31:0] AMASK =
    (ADDRESS_WIDTH >= 32) ? 32'hFFFFFFFF : 32'((64'd1 << ADDRESS_WIDTH) - 64'd1);

  logic [31:0]                addr_r, addr_nxt;
  logic [127:0]               data_r, data_nxt;
  logic [vap_pkg::BCNT_W-1:0] bcnt_r, bcnt_nxt;

  always_comb begin
    logic [2:0] sz;
    logic [2:0] cnt;
    sz  = vap_pkg::elem_size(fmt);
    cnt = (32'(count_cfg) > COMPONENTS) ? 3'(COMPONENTS) : count_cfg;
    data_nxt = '0;
    for (int i = 0; i < COMPONENTS; i++) begin
      if (3'(i) < cnt) begin
        unique case (sz)
          3'd4:    data_nxt[32*i +: 32] = codes[i];
          3'd2:    data_nxt[16*i +: 16] = codes[i][15:0];
          3'd1:    data_nxt[8*i +: 8]   = codes[i][7:0];
          default: ;
        endcase
      end
    end
    bcnt_nxt = 5'(cnt) * 5'(sz);
    addr_nxt = (base + 32'(offset)) & AMASK;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  assign write_address = addr_r;
  assign packed_low    = data_r[63:0];
  assign packed_high   = data_r[127:64];
  assign byte_count    = bcnt_r;

endmodule

// ===== rtl/vertex_attribute_pack_top.sv =====
`timescale 1ns / 1ps
// Vertex attribute packer.
// in_ channel: one beat per vertex carrying four float32 components and the
// vertex base address. out_ channel: one beat per input beat with the write
// address, up to sixteen packed bytes and the byte count.
// The cfg_ port selects the element format, the component count and the
// attribute offset; it should only be written while no beat is in flight.
// An accepted input beat reaches out_tvalid through a multiply stage per lane,
// a rounding and clamping stage per lane, and the merge stage that packs the
// lanes into the output register.
// Throughput is one beat per cycle while the receiver does not stall; each
// component has its own lane.
// Every stage holds its own valid flag, so a stalled receiver only stops the
// input once all three stages are full; bubbles are squeezed out meanwhile.
// Reset clears the stage valids and restores the registers to float32,
// four components and a zero offset.
module vertex_attribute_pack_top #(
  parameter int COMPONENTS    = vap_pkg::COMPONENTS_DEF,
  parameter int ADDRESS_WIDTH = vap_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // component_x, component_y, component_z, component_w, vertex_base
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // write_address, packed_low, packed_high, byte_count, zero pad
  output logic [167:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [vap_pkg::FMT_W-1:0]   fmt_r;
  logic [vap_pkg::COUNT_W-1:0] count_r;
  logic [vap_pkg::OFFS_W-1:0]  offset_r;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= vap_pkg::FMT_FLOAT32;
      count_r  <= 3'd4;
      offset_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        vap_pkg::REG_FORMAT: fmt_r    <= cfg_pwdata[3:0];
        vap_pkg::REG_COUNT:  count_r  <= cfg_pwdata[2:0];
        vap_pkg::REG_OFFSET: offset_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      vap_pkg::REG_FORMAT: cfg_prdata = 32'(fmt_r);
      vap_pkg::REG_COUNT:  cfg_prdata = 32'(count_r);
      vap_pkg::REG_OFFSET: cfg_prdata = 32'(offset_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Stage handshakes: a stage loads when it is empty or its successor moves on.
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  vap_pkg::stage_en_t lane_en;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign lane_en.s1 = rdy1;
  assign lane_en.s2 = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  logic [31:0] base1_r, base2_r;
  always_ff @(posedge clk) begin
    if (rdy1) base1_r <= in_tdata[159:128];
    if (rdy2) base2_r <= base1_r;
  end

  logic [vap_pkg::CODE_W-1:0] codes [COMPONENTS];

  for (genvar i = 0; i < COMPONENTS; i++) begin : g_lane
    vap_lane u_lane (
      .clk  (clk),
      .en   (lane_en),
      .fmt  (fmt_r),
      .comp (in_tdata[32*i +: 32]),
      .code (codes[i])
    );
  end

  logic [31:0] write_address;
  logic [63:0] packed_low, packed_high;
  logic [4:0]  byte_count;

  vap_merge #(
    .COMPONENTS    (COMPONENTS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_merge (
    .clk           (clk),
    .en            (rdy3),
    .fmt           (fmt_r),
    .count_cfg     (count_r),
    .offset        (offset_r),
    .base          (base2_r),
    .codes         (codes),
    .write_address (write_address),
    .packed_low    (packed_low),
    .packed_high   (packed_high),
    .byte_count    (byte_count)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = {3'd0, byte_count, packed_high, packed_low, write_address};

endmodule

// ===== rtl/vap_checker.sv =====
`timescale 1ns / 1ps
module vap_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [167:0] out_tdata,
  input logic         cfg_pready
);

  // A beat held back by the receiver stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[164:160] <= 5'd16)
    else $error("byte count beyond sixteen");

  // With nothing written, both packed words are zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[164:160] == 5'd0 |-> out_tdata[159:32] == 128'd0)
    else $error("packed data present with zero byte count");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind vertex_attribute_pack_top vap_checker u_vap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
